[design/kahn_wave_topo_sorter_top_defines.svh]
// Assertion macros used by the sorter top level.
`ifndef KAHN_WAVE_TOPO_SORTER_TOP_DEFINES_SVH
`define KAHN_WAVE_TOPO_SORTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define KWTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwts assertion failed");

// Next-cycle implication, disabled while reset is low.
`define KWTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwts assertion failed");

`endif

[design/kwts_pkg.sv]
// Shared constants, command codes and control types for the wave sorter.
package kwts_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;
  localparam int PRIO_BITS_DEF = 16;

  localparam int CMD_W    = 3;
  localparam int NODE_W   = 6;
  localparam int EIDX_W   = 8;
  localparam int PRIO_IN_W = 16;
  localparam int STAT_W   = 2;
  localparam int ID_W     = 8;
  localparam int WAVE_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_SET_PRIO = 3'd1,
    CMD_CONNECT  = 3'd2,
    CMD_RM_NODE  = 3'd3,
    CMD_RM_EDGE  = 3'd4,
    CMD_BAKE     = 3'd5
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // control from the sequencer to the priority compare unit
  typedef struct packed {
    logic clear;
    logic step;
    logic cand_ok;
  } cmp_ctl_t;

endpackage

[design/kwts_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module kwts_ram #(
  parameter int W = 8,
  parameter int D = 4,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic [AW-1:0] ra,
  output logic [W-1:0]  rd
);

  logic [W-1:0] mem [0:D-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

[design/kwts_prio_cmp.sv]
// Priority compare unit: keeps the running best of a wave scan, first wins ties.
module kwts_prio_cmp #(
  parameter int PB = 16,
  parameter int NW = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kwts_pkg::cmp_ctl_t    ctl,
  input  logic signed [PB-1:0]  prio,
  input  logic [NW-1:0]         node,
  input  logic [NW-1:0]         k,
  output logic                  have_best,
  output logic [NW-1:0]         best_node,
  output logic [NW-1:0]         best_k
);

  logic                 have_r;
  logic signed [PB-1:0] best_prio_r;
  logic [NW-1:0]        best_node_r;
  logic [NW-1:0]        best_k_r;
  logic                 take;

  // strict greater keeps the earlier entry on equal priority
  assign take = ctl.step && ctl.cand_ok && (!have_r || (prio > best_prio_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.clear) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r      <= 1'b1;
      best_prio_r <= prio;
      best_node_r <= node;
      best_k_r    <= k;
    end
  end

  assign have_best = have_r;
  assign best_node = best_node_r;
  assign best_k    = best_k_r;

endmodule

[design/kahn_wave_topo_sorter_top.sv]
// Top level of the Kahn wave topological sorter: command sequencer and tables.
//
//  channel | ports                                               | dir
//  in      | in_valid/in_ready, command, node_a/b, edge_index,    | in
//          | priority_req                                        |
//  out     | out_valid/out_ready, status, new_id, order_valid,   | out
//          | sorted_node, wave_index, wave_last, last            |
//
// Remove node sweeps the edge table through its one read port, over every edge
// handed out so far. Bake clears the pending counts, counts each node's live
// incoming edges, collects wave 0, then per emitted node scans its wave for the
// best priority and sweeps the edge table to release the node's successors.
// Reset clears counts and alive marks at once; no clearing pass is needed.
// Input is taken only when the sequencer is idle; the result register lets the
// next command in while a result waits, and the sequencer holds on a full one.
`include "kahn_wave_topo_sorter_top_defines.svh"

module kahn_wave_topo_sorter_top #(
  parameter int MAX_NODES = kwts_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = kwts_pkg::MAX_EDGES_DEF,
  parameter int PRIO_BITS = kwts_pkg::PRIO_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kwts_pkg::CMD_W-1:0]      in_command,
  input  logic [kwts_pkg::NODE_W-1:0]     in_node_a,
  input  logic [kwts_pkg::NODE_W-1:0]     in_node_b,
  input  logic [kwts_pkg::EIDX_W-1:0]     in_edge_index,
  input  logic signed [kwts_pkg::PRIO_IN_W-1:0] in_priority_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kwts_pkg::STAT_W-1:0]     out_status,
  output logic [kwts_pkg::ID_W-1:0]       out_new_id,
  output logic                            out_order_valid,
  output logic [kwts_pkg::NODE_W-1:0]     out_sorted_node,
  output logic [kwts_pkg::WAVE_W-1:0]     out_wave_index,
  output logic                            out_wave_last,
  output logic                            out_last
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int EW   = $clog2(MAX_EDGES);
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int EDW  = 1 + 2 * NW;
  localparam int WBW  = PRIO_BITS + NW;
  localparam int WD   = 2 * (1 << NW);
  localparam int NCMP = NCW + kwts_pkg::NODE_W;
  localparam int ECMP = ECW + kwts_pkg::EIDX_W;
  localparam logic signed [32:0] PLO = -(33'sd1 <<< (PRIO_BITS - 1));
  localparam logic signed [32:0] PHI = (33'sd1 <<< (PRIO_BITS - 1)) - 33'sd1;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_RESP, S_RN_RD, S_RN_CHK, S_RE_CHK,
    S_CLR, S_CNT_RD, S_CNT_CHK, S_CNT_WR, S_W0_RD, S_W0_CHK,
    S_WAVE, S_SEL_RD, S_SEL_CMP, S_REL_RD, S_REL_CHK, S_REL_WR,
    S_OUT, S_EMPTY
  } state_t;

  state_t state_r;

  logic [kwts_pkg::CMD_W-1:0]      cmd_r;
  logic [kwts_pkg::NODE_W-1:0]     a_r;
  logic [kwts_pkg::NODE_W-1:0]     b_r;
  logic [kwts_pkg::EIDX_W-1:0]     ei_r;
  logic signed [kwts_pkg::PRIO_IN_W-1:0] pri_r;

  logic [NCW-1:0]       node_cnt_r;
  logic [ECW-1:0]       edge_cnt_r;
  logic [MAX_NODES-1:0] alive_r;
  logic [MAX_NODES-1:0] taken_r;
  logic [ECW-1:0]       idx_r;
  logic [NCW-1:0]       ni_r;
  logic [NCW-1:0]       k_r;
  logic [NCW-1:0]       ncur_r;
  logic [NCW-1:0]       nnxt_r;
  logic [NCW-1:0]       sel_cnt_r;
  logic                 half_r;
  logic [kwts_pkg::WAVE_W-1:0] wave_r;
  logic [NW-1:0]        dst_r;
  logic [kwts_pkg::STAT_W-1:0] res_status_r;
  logic [kwts_pkg::ID_W-1:0]   res_id_r;

  logic                           out_valid_r;
  logic [kwts_pkg::STAT_W-1:0]    out_status_r;
  logic [kwts_pkg::ID_W-1:0]      out_new_id_r;
  logic                           out_order_valid_r;
  logic [kwts_pkg::NODE_W-1:0]    out_sorted_node_r;
  logic [kwts_pkg::WAVE_W-1:0]    out_wave_index_r;
  logic                           out_wave_last_r;
  logic                           out_last_r;

  // RAM ports
  logic           e_we;
  logic [EW-1:0]  e_wa, e_ra;
  logic [EDW-1:0] e_wd, e_rd;
  logic           p_we;
  logic [NW-1:0]  p_wa, p_ra;
  logic [ECW-1:0] p_wd, p_rd;
  logic           q_we;
  logic [NW-1:0]  q_wa, q_ra;
  logic [PRIO_BITS-1:0] q_wd, q_rd;
  logic           w_we;
  logic [NW:0]    w_wa, w_ra;
  logic [WBW-1:0] w_wd, w_rd;

  logic           e_alive;
  logic [NW-1:0]  e_src, e_dst;
  logic           ok_a, ok_b, node_full, edge_full, ei_ok, slot_free;
  logic           wave_last, w0_hit, emit;
  logic signed [32:0] pext, pclamp;

  kwts_pkg::cmp_ctl_t cmp_ctl;
  logic               have_best;
  logic [NW-1:0]      best_node, best_k;

  assign e_alive = e_rd[EDW-1];
  assign e_src   = e_rd[2*NW-1:NW];
  assign e_dst   = e_rd[NW-1:0];

  assign ok_a = (NCMP'(a_r) < NCMP'(node_cnt_r)) && alive_r[a_r[NW-1:0]];
  assign ok_b = (NCMP'(b_r) < NCMP'(node_cnt_r)) && alive_r[b_r[NW-1:0]];
  assign node_full = (node_cnt_r == NCW'(MAX_NODES));
  assign edge_full = (edge_cnt_r == ECW'(MAX_EDGES));
  assign ei_ok     = (ECMP'(ei_r) < ECMP'(edge_cnt_r));
  assign slot_free = !out_valid_r || out_ready;
  assign wave_last = ((sel_cnt_r + NCW'(1)) == ncur_r);
  assign w0_hit    = alive_r[ni_r[NW-1:0]] && (p_rd == '0);
  // a result beat is loaded this cycle
  assign emit      = slot_free &&
                     ((state_r == S_RESP) || (state_r == S_OUT) || (state_r == S_EMPTY));

  assign pext   = 33'(pri_r);
  assign pclamp = (pext < PLO) ? PLO : ((pext > PHI) ? PHI : pext);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = idx_r[EW-1:0];
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = e_dst;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = e_dst;
    w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = {half_r, k_r[NW-1:0]};
    cmp_ctl.clear   = (state_r == S_SEL_RD) && (k_r == '0);
    cmp_ctl.step    = (state_r == S_SEL_CMP);
    cmp_ctl.cand_ok = !taken_r[k_r[NW-1:0]];
    case (state_r)
      S_EXEC: begin
        e_ra = EW'(ei_r);
        case (cmd_r)
          kwts_pkg::CMD_ADD: begin
            q_we = !node_full;
            q_wa = node_cnt_r[NW-1:0];
          end
          kwts_pkg::CMD_SET_PRIO: begin
            q_we = ok_a;
            q_wa = a_r[NW-1:0];
            q_wd = pclamp[PRIO_BITS-1:0];
          end
          kwts_pkg::CMD_CONNECT: begin
            e_we = ok_a && ok_b && !edge_full;
            e_wa = edge_cnt_r[EW-1:0];
            e_wd = {1'b1, a_r[NW-1:0], b_r[NW-1:0]};
          end
          default: ;
        endcase
      end
      S_RN_CHK: begin
        e_we = e_alive && ((e_src == a_r[NW-1:0]) || (e_dst == a_r[NW-1:0]));
        e_wa = idx_r[EW-1:0];
        e_wd = {1'b0, e_src, e_dst};
      end
      S_RE_CHK: begin
        e_we = e_alive;
        e_wa = EW'(ei_r);
        e_wd = {1'b0, e_src, e_dst};
      end
      S_CLR: begin
        p_we = (ni_r != node_cnt_r);
        p_wa = ni_r[NW-1:0];
      end
      S_CNT_WR: begin
        p_we = 1'b1;
        p_wa = dst_r;
        p_wd = p_rd + ECW'(1);
      end
      S_W0_RD: begin
        p_ra = ni_r[NW-1:0];
        q_ra = ni_r[NW-1:0];
      end
      S_W0_CHK: begin
        w_we = w0_hit;
        w_wa = {half_r, ncur_r[NW-1:0]};
        w_wd = {q_rd, ni_r[NW-1:0]};
      end
      S_REL_WR: begin
        p_we = (p_rd != '0);
        p_wa = dst_r;
        p_wd = p_rd - ECW'(1);
        w_we = (p_rd == ECW'(1)) && (nnxt_r != NCW'(MAX_NODES));
        w_wa = {!half_r, nnxt_r[NW-1:0]};
        w_wd = {q_rd, dst_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      node_cnt_r  <= '0;
      edge_cnt_r  <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            a_r     <= in_node_a;
            b_r     <= in_node_b;
            ei_r    <= in_edge_index;
            pri_r   <= in_priority_req;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_r)
            kwts_pkg::CMD_ADD: begin
              state_r <= S_RESP;
              if (node_full) begin
                res_status_r <= kwts_pkg::ST_FULL;
                res_id_r     <= '0;
              end else begin
                alive_r[node_cnt_r[NW-1:0]] <= 1'b1;
                res_status_r <= kwts_pkg::ST_DONE;
                res_id_r     <= kwts_pkg::ID_W'(node_cnt_r);
                node_cnt_r   <= node_cnt_r + NCW'(1);
              end
            end
            kwts_pkg::CMD_SET_PRIO: begin
              res_status_r <= ok_a ? kwts_pkg::ST_DONE : kwts_pkg::ST_INVALID;
              res_id_r     <= '0;
              state_r      <= S_RESP;
            end
            kwts_pkg::CMD_CONNECT: begin
              state_r <= S_RESP;
              if (ok_a && ok_b && !edge_full) begin
                res_status_r <= kwts_pkg::ST_DONE;
                res_id_r     <= kwts_pkg::ID_W'(edge_cnt_r);
                edge_cnt_r   <= edge_cnt_r + ECW'(1);
              end else begin
                res_status_r <= (ok_a && ok_b) ? kwts_pkg::ST_FULL : kwts_pkg::ST_INVALID;
                res_id_r     <= '0;
              end
            end
            kwts_pkg::CMD_RM_NODE: begin
              res_id_r <= '0;
              if (ok_a) begin
                idx_r   <= '0;
                state_r <= S_RN_RD;
              end else begin
                res_status_r <= kwts_pkg::ST_INVALID;
                state_r      <= S_RESP;
              end
            end
            kwts_pkg::CMD_RM_EDGE: begin
              res_id_r <= '0;
              if (ei_ok) begin
                state_r <= S_RE_CHK;
              end else begin
                res_status_r <= kwts_pkg::ST_INVALID;
                state_r      <= S_RESP;
              end
            end
            kwts_pkg::CMD_BAKE: begin
              ni_r    <= '0;
              ncur_r  <= '0;
              nnxt_r  <= '0;
              wave_r  <= '0;
              half_r  <= 1'b0;
              state_r <= S_CLR;
            end
            default: begin
              res_status_r <= kwts_pkg::ST_INVALID;
              res_id_r     <= '0;
              state_r      <= S_RESP;
            end
          endcase
        end
        S_RN_RD: begin
          if (idx_r == edge_cnt_r) begin
            alive_r[a_r[NW-1:0]] <= 1'b0;
            res_status_r <= kwts_pkg::ST_DONE;
            state_r      <= S_RESP;
          end else begin
            state_r <= S_RN_CHK;
          end
        end
        S_RN_CHK: begin
          idx_r   <= idx_r + ECW'(1);
          state_r <= S_RN_RD;
        end
        S_RE_CHK: begin
          res_status_r <= e_alive ? kwts_pkg::ST_DONE : kwts_pkg::ST_INVALID;
          state_r      <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            out_status_r      <= res_status_r;
            out_new_id_r      <= res_id_r;
            out_order_valid_r <= 1'b0;
            out_sorted_node_r <= '0;
            out_wave_index_r  <= '0;
            out_wave_last_r   <= 1'b0;
            out_last_r        <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_CLR: begin
          if (ni_r == node_cnt_r) begin
            idx_r   <= '0;
            state_r <= S_CNT_RD;
          end else begin
            ni_r <= ni_r + NCW'(1);
          end
        end
        S_CNT_RD: begin
          if (idx_r == edge_cnt_r) begin
            ni_r    <= '0;
            state_r <= S_W0_RD;
          end else begin
            state_r <= S_CNT_CHK;
          end
        end
        S_CNT_CHK: begin
          if (e_alive) begin
            dst_r   <= e_dst;
            state_r <= S_CNT_WR;
          end else begin
            idx_r   <= idx_r + ECW'(1);
            state_r <= S_CNT_RD;
          end
        end
        S_CNT_WR: begin
          idx_r   <= idx_r + ECW'(1);
          state_r <= S_CNT_RD;
        end
        S_W0_RD: begin
          state_r <= (ni_r == node_cnt_r) ? S_WAVE : S_W0_CHK;
        end
        S_W0_CHK: begin
          if (w0_hit) begin
            ncur_r <= ncur_r + NCW'(1);
          end
          ni_r    <= ni_r + NCW'(1);
          state_r <= S_W0_RD;
        end
        S_WAVE: begin
          if (ncur_r == '0) begin
            state_r <= S_EMPTY;
          end else begin
            taken_r   <= '0;
            sel_cnt_r <= '0;
            nnxt_r    <= '0;
            k_r       <= '0;
            state_r   <= S_SEL_RD;
          end
        end
        S_SEL_RD: begin
          if (k_r == ncur_r) begin
            taken_r[best_k] <= 1'b1;
            idx_r           <= '0;
            state_r         <= S_REL_RD;
          end else begin
            state_r <= S_SEL_CMP;
          end
        end
        S_SEL_CMP: begin
          k_r     <= k_r + NCW'(1);
          state_r <= S_SEL_RD;
        end
        S_REL_RD: begin
          state_r <= (idx_r == edge_cnt_r) ? S_OUT : S_REL_CHK;
        end
        S_REL_CHK: begin
          if (e_alive && (e_src == best_node)) begin
            dst_r   <= e_dst;
            state_r <= S_REL_WR;
          end else begin
            idx_r   <= idx_r + ECW'(1);
            state_r <= S_REL_RD;
          end
        end
        S_REL_WR: begin
          if ((p_rd == ECW'(1)) && (nnxt_r != NCW'(MAX_NODES))) begin
            nnxt_r <= nnxt_r + NCW'(1);
          end
          idx_r   <= idx_r + ECW'(1);
          state_r <= S_REL_RD;
        end
        S_OUT: begin
          if (slot_free) begin
            out_status_r      <= kwts_pkg::ST_DONE;
            out_new_id_r      <= '0;
            out_order_valid_r <= 1'b1;
            out_sorted_node_r <= kwts_pkg::NODE_W'(best_node);
            out_wave_index_r  <= wave_r;
            out_wave_last_r   <= wave_last;
            out_last_r        <= wave_last && (nnxt_r == '0);
            if (wave_last) begin
              if (nnxt_r == '0) begin
                state_r <= S_IDLE;
              end else begin
                half_r  <= !half_r;
                ncur_r  <= nnxt_r;
                wave_r  <= wave_r + kwts_pkg::WAVE_W'(1);
                state_r <= S_WAVE;
              end
            end else begin
              sel_cnt_r <= sel_cnt_r + NCW'(1);
              k_r       <= '0;
              state_r   <= S_SEL_RD;
            end
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            out_status_r      <= kwts_pkg::ST_DONE;
            out_new_id_r      <= '0;
            out_order_valid_r <= 1'b0;
            out_sorted_node_r <= '0;
            out_wave_index_r  <= '0;
            out_wave_last_r   <= 1'b0;
            out_last_r        <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  kwts_ram #(.W(EDW), .D(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .wa(e_wa), .wd(e_wd), .ra(e_ra), .rd(e_rd)
  );

  kwts_ram #(.W(ECW), .D(MAX_NODES)) u_pend_ram (
    .clk(clk), .we(p_we), .wa(p_wa), .wd(p_wd), .ra(p_ra), .rd(p_rd)
  );

  kwts_ram #(.W(PRIO_BITS), .D(MAX_NODES)) u_prio_ram (
    .clk(clk), .we(q_we), .wa(q_wa), .wd(q_wd), .ra(q_ra), .rd(q_rd)
  );

  // two halves: current wave and next wave, swapped per wave
  kwts_ram #(.W(WBW), .D(WD)) u_wave_ram (
    .clk(clk), .we(w_we), .wa(w_wa), .wd(w_wd), .ra(w_ra), .rd(w_rd)
  );

  kwts_prio_cmp #(.PB(PRIO_BITS), .NW(NW)) u_cmp (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(cmp_ctl),
    .prio(w_rd[WBW-1:NW]),
    .node(w_rd[NW-1:0]),
    .k(k_r[NW-1:0]),
    .have_best(have_best),
    .best_node(best_node),
    .best_k(best_k)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_new_id      = out_new_id_r;
  assign out_order_valid = out_order_valid_r;
  assign out_sorted_node = out_sorted_node_r;
  assign out_wave_index  = out_wave_index_r;
  assign out_wave_last   = out_wave_last_r;
  assign out_last        = out_last_r;

  `KWTS_ASSERT_NOW(a_node_cnt_max, clk, rst_n, 1'b1, node_cnt_r <= NCW'(MAX_NODES))
  `KWTS_ASSERT_NOW(a_edge_cnt_max, clk, rst_n, 1'b1, edge_cnt_r <= ECW'(MAX_EDGES))
  `KWTS_ASSERT_NOW(a_out_has_best, clk, rst_n, state_r == S_OUT, have_best)
  `KWTS_ASSERT_NOW(a_last_ends_wave, clk, rst_n,
                   out_valid_r && out_order_valid_r && out_last_r, out_wave_last_r)
  `KWTS_ASSERT_NEXT(a_node_cnt_mono, clk, rst_n, 1'b1, node_cnt_r >= $past(node_cnt_r))

endmodule

[tb/kahn_wave_topo_sorter_checker.sv]
// Checker for the wave sorter: predicts each command's results and compares out beats.
module kahn_wave_topo_sorter_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [kwts_pkg::CMD_W-1:0]            in_command,
  input  logic [kwts_pkg::NODE_W-1:0]           in_node_a,
  input  logic [kwts_pkg::NODE_W-1:0]           in_node_b,
  input  logic [kwts_pkg::EIDX_W-1:0]           in_edge_index,
  input  logic signed [kwts_pkg::PRIO_IN_W-1:0] in_priority_req,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [kwts_pkg::STAT_W-1:0]           out_status,
  input  logic [kwts_pkg::ID_W-1:0]             out_new_id,
  input  logic                                  out_order_valid,
  input  logic [kwts_pkg::NODE_W-1:0]           out_sorted_node,
  input  logic [kwts_pkg::WAVE_W-1:0]           out_wave_index,
  input  logic                                  out_wave_last,
  input  logic                                  out_last,
  output int                                    fail_count,
  output int                                    results_pending
);

  localparam int NODES = kwts_pkg::MAX_NODES_DEF;
  localparam int EDGES = kwts_pkg::MAX_EDGES_DEF;

  typedef struct {
    logic [kwts_pkg::STAT_W-1:0] status;
    logic [kwts_pkg::ID_W-1:0]   new_id;
    logic                        order_valid;
    logic [kwts_pkg::NODE_W-1:0] node;
    logic [kwts_pkg::WAVE_W-1:0] wave;
    logic                        wave_last;
    logic                        last;
  } beat_t;

  beat_t expected_beats[$];

  int                                    node_cnt;
  bit                                    node_live[NODES];
  logic signed [kwts_pkg::PRIO_IN_W-1:0] node_pri[NODES];
  int                                    edge_cnt;
  bit                                    edge_live[EDGES];
  int                                    edge_from[EDGES];
  int                                    edge_to[EDGES];

  function automatic void push_beat(logic [kwts_pkg::STAT_W-1:0] st, int id, bit ov, int nd,
                                    int wv, bit wl, bit lst);
    beat_t b;
    b.status = st; b.new_id = id[kwts_pkg::ID_W-1:0]; b.order_valid = ov;
    b.node = nd[kwts_pkg::NODE_W-1:0]; b.wave = wv[kwts_pkg::WAVE_W-1:0];
    b.wave_last = wl; b.last = lst;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic bit node_usable(int n);
    return n < node_cnt && node_live[n];
  endfunction

  // Kahn waves, each stably sorted by descending priority
  function automatic void predict_bake();
    int pend[NODES];
    int cur[$];
    int nxt[$];
    int emitted;
    int wave;
    int v;
    int j;
    int d;
    emitted = 0;
    wave = 0;
    foreach (pend[i]) pend[i] = 0;
    for (int e = 0; e < edge_cnt; e++)
      if (edge_live[e]) pend[edge_to[e]]++;
    for (int i = 0; i < node_cnt; i++)
      if (node_live[i] && pend[i] == 0) cur.insert(cur.size(), i);
    while (cur.size() > 0) begin
      for (int i = 1; i < cur.size(); i++) begin
        v = cur[i];
        j = i;
        while (j > 0 && node_pri[cur[j-1]] < node_pri[v]) begin
          cur[j] = cur[j-1];
          j--;
        end
        cur[j] = v;
      end
      for (int i = 0; i < cur.size() && emitted < NODES; i++) begin
        push_beat(kwts_pkg::ST_DONE, 0, 1'b1, cur[i], wave, i + 1 == cur.size(), 1'b0);
        emitted++;
      end
      nxt.delete();
      foreach (cur[i])
        for (int e = 0; e < edge_cnt; e++) begin
          if (!edge_live[e] || edge_from[e] != cur[i]) continue;
          d = edge_to[e];
          if (pend[d] == 0) continue;
          pend[d]--;
          if (pend[d] == 0) nxt.insert(nxt.size(), d);
        end
      cur = nxt;
      wave++;
    end
    if (emitted == 0) push_beat(kwts_pkg::ST_DONE, 0, 1'b0, 0, 0, 1'b0, 1'b1);
    else expected_beats[expected_beats.size()-1].last = 1'b1;
  endfunction

  function automatic void predict_command(logic [kwts_pkg::CMD_W-1:0] cmd, int a, int b,
                                          int ei,
                                          logic signed [kwts_pkg::PRIO_IN_W-1:0] pri);
    case (cmd)
      kwts_pkg::CMD_ADD: begin
        if (node_cnt >= NODES) begin
          push_beat(kwts_pkg::ST_FULL, 0, 0, 0, 0, 0, 1);
        end else begin
          node_live[node_cnt] = 1;
          node_pri[node_cnt] = '0;
          push_beat(kwts_pkg::ST_DONE, node_cnt, 0, 0, 0, 0, 1);
          node_cnt++;
        end
      end
      kwts_pkg::CMD_SET_PRIO: begin
        if (node_usable(a)) begin
          node_pri[a] = pri;
          push_beat(kwts_pkg::ST_DONE, 0, 0, 0, 0, 0, 1);
        end else push_beat(kwts_pkg::ST_INVALID, 0, 0, 0, 0, 0, 1);
      end
      kwts_pkg::CMD_CONNECT: begin
        if (!node_usable(a) || !node_usable(b)) begin
          push_beat(kwts_pkg::ST_INVALID, 0, 0, 0, 0, 0, 1);
        end else if (edge_cnt >= EDGES) begin
          push_beat(kwts_pkg::ST_FULL, 0, 0, 0, 0, 0, 1);
        end else begin
          edge_live[edge_cnt] = 1;
          edge_from[edge_cnt] = a;
          edge_to[edge_cnt] = b;
          push_beat(kwts_pkg::ST_DONE, edge_cnt, 0, 0, 0, 0, 1);
          edge_cnt++;
        end
      end
      kwts_pkg::CMD_RM_NODE: begin
        if (node_usable(a)) begin
          for (int e = 0; e < edge_cnt; e++)
            if (edge_live[e] && (edge_from[e] == a || edge_to[e] == a)) edge_live[e] = 0;
          node_live[a] = 0;
          push_beat(kwts_pkg::ST_DONE, 0, 0, 0, 0, 0, 1);
        end else push_beat(kwts_pkg::ST_INVALID, 0, 0, 0, 0, 0, 1);
      end
      kwts_pkg::CMD_RM_EDGE: begin
        if (ei < edge_cnt && edge_live[ei]) begin
          edge_live[ei] = 0;
          push_beat(kwts_pkg::ST_DONE, 0, 0, 0, 0, 0, 1);
        end else push_beat(kwts_pkg::ST_INVALID, 0, 0, 0, 0, 0, 1);
      end
      kwts_pkg::CMD_BAKE: predict_bake();
      default: push_beat(kwts_pkg::ST_INVALID, 0, 0, 0, 0, 0, 1);
    endcase
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t b;
    if (!rst_n) begin
      node_cnt = 0;
      edge_cnt = 0;
      foreach (node_live[i]) begin
        node_live[i] = 0;
        node_pri[i] = '0;
      end
      foreach (edge_live[i]) edge_live[i] = 0;
      expected_beats.delete();
      fail_count = 0;
      results_pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          b = expected_beats.pop_front();
          check_field("status", b.status, out_status);
          check_field("new_id", b.new_id, out_new_id);
          check_field("order_valid", b.order_valid, out_order_valid);
          check_field("sorted_node", b.node, out_sorted_node);
          check_field("wave_index", b.wave, out_wave_index);
          check_field("wave_last", b.wave_last, out_wave_last);
          check_field("last", b.last, out_last);
        end
      end
      if (in_valid && in_ready)
        predict_command(in_command, in_node_a, in_node_b, in_edge_index, in_priority_req);
      results_pending <= expected_beats.size();
    end
  end

endmodule

[tb/tb_kahn_wave_topo_sorter_top.sv]
// Testbench top for the wave sorter: command stimulus, back-pressure and verdict.
module tb_kahn_wave_topo_sorter_top;

  localparam logic [kwts_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [kwts_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 100000000;
  localparam int RANDOM_ITEMS = 346;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_ready;
  logic [kwts_pkg::CMD_W-1:0]            in_command;
  logic [kwts_pkg::NODE_W-1:0]           in_node_a;
  logic [kwts_pkg::NODE_W-1:0]           in_node_b;
  logic [kwts_pkg::EIDX_W-1:0]           in_edge_index;
  logic signed [kwts_pkg::PRIO_IN_W-1:0] in_priority_req;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [kwts_pkg::STAT_W-1:0]           out_status;
  logic [kwts_pkg::ID_W-1:0]             out_new_id;
  logic                                  out_order_valid;
  logic [kwts_pkg::NODE_W-1:0]           out_sorted_node;
  logic [kwts_pkg::WAVE_W-1:0]           out_wave_index;
  logic                                  out_wave_last;
  logic                                  out_last;
  int                                    fail_count;
  int                                    results_pending;
  int                                    cycle_cnt = 0;
  int                                    nodes_added;
  bit                                    sender_calm;

  kahn_wave_topo_sorter_top u_dut (.*);

  kahn_wave_topo_sorter_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    // long ready stretch early on, random stalls otherwise
    if (cycle_cnt > 3000 && cycle_cnt < 40000) out_ready <= 1'b1;
    else out_ready <= $urandom_range(0, 99) >= 21;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(logic [kwts_pkg::CMD_W-1:0] cmd, int a, int b, int ei, int pri);
    while (!sender_calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_node_a <= a[kwts_pkg::NODE_W-1:0];
    in_node_b <= b[kwts_pkg::NODE_W-1:0];
    in_edge_index <= ei[kwts_pkg::EIDX_W-1:0];
    in_priority_req <= pri[kwts_pkg::PRIO_IN_W-1:0];
    if (cmd == kwts_pkg::CMD_ADD && nodes_added < 64) nodes_added++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int pick_node();
    if ($urandom_range(0, 9) == 0 || nodes_added == 0) return $urandom_range(0, 63);
    return $urandom_range(0, nodes_added - 1);
  endfunction

  initial begin
    int r;
    int idle_wait;
    nodes_added = 0;
    sender_calm = 0;
    in_valid <= 1'b0;
    in_command <= kwts_pkg::CMD_ADD;
    in_node_a <= '0;
    in_node_b <= '0;
    in_edge_index <= '0;
    in_priority_req <= '0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty graph, extremes, bad operands, spare codes, loops
    send(kwts_pkg::CMD_BAKE, 0, 0, 0, 0);
    send(kwts_pkg::CMD_ADD, 0, 0, 0, 0);
    send(kwts_pkg::CMD_ADD, 0, 0, 0, 0);
    send(kwts_pkg::CMD_ADD, 0, 0, 0, 0);
    send(kwts_pkg::CMD_SET_PRIO, 1, 0, 0, 32767);
    send(kwts_pkg::CMD_SET_PRIO, 2, 0, 0, -32768);
    send(kwts_pkg::CMD_SET_PRIO, 63, 0, 0, 5);
    send(kwts_pkg::CMD_CONNECT, 0, 1, 0, 0);
    send(kwts_pkg::CMD_CONNECT, 0, 2, 0, 0);
    send(kwts_pkg::CMD_CONNECT, 0, 2, 0, 0);
    send(kwts_pkg::CMD_CONNECT, 0, 63, 0, 0);
    send(kwts_pkg::CMD_RM_EDGE, 0, 0, 255, 0);
    send(CMD_SPARE_LO, 63, 63, 255, -1);
    send(CMD_SPARE_HI, 0, 0, 0, 0);
    send(kwts_pkg::CMD_BAKE, 0, 0, 0, 0);
    send(kwts_pkg::CMD_ADD, 0, 0, 0, 0);
    send(kwts_pkg::CMD_CONNECT, 3, 3, 0, 0);
    send(kwts_pkg::CMD_BAKE, 0, 0, 0, 0);
    send(kwts_pkg::CMD_RM_EDGE, 0, 0, 3, 0);
    send(kwts_pkg::CMD_RM_EDGE, 0, 0, 3, 0);
    send(kwts_pkg::CMD_RM_NODE, 2, 0, 0, 0);
    send(kwts_pkg::CMD_SET_PRIO, 2, 0, 0, 1);
    send(kwts_pkg::CMD_RM_NODE, 2, 0, 0, 0);
    send(kwts_pkg::CMD_BAKE, 0, 0, 0, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_calm = (i >= 100 && i < 180);
      if (i == 200) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 12) send(kwts_pkg::CMD_ADD, 0, 0, 0, 0);
      else if (r < 19)
        send(kwts_pkg::CMD_SET_PRIO, pick_node(), 0, 0, $urandom_range(0, 65535));
      else if (r < 89) send(kwts_pkg::CMD_CONNECT, pick_node(), pick_node(), 0, 0);
      else if (r < 91) send(kwts_pkg::CMD_RM_NODE, pick_node(), 0, 0, 0);
      else if (r < 95) send(kwts_pkg::CMD_RM_EDGE, 0, 0, $urandom_range(0, 255), 0);
      else if (r < 99)
        send(kwts_pkg::CMD_BAKE, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0);
      else send($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI, 0, 0, 0, 0);
    end
    in_valid <= 1'b0;

    while (results_pending != 0) @(posedge clk);
    idle_wait = 0;
    while (idle_wait < 2000) begin
      @(posedge clk);
      idle_wait++;
    end
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
